FILE: rtl/bads_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bads_pkg
// shared constants, types and helpers of the block average downscaler
// ----------------------------------------------------------------------------
package bads_pkg;

  localparam int MAX_DST_WIDTH = 256;
  localparam int MAX_SRC_DIM   = 2048;
  localparam int DST_H_LIMIT   = 256;
  localparam int POS_W         = 11;
  localparam int IDX_W         = 9;
  localparam int ADDR_W        = 8;
  localparam int SUM_W         = 32;
  localparam int CNT_W         = 24;
  localparam int DIV_W         = 32;
  localparam int SRC_W         = 12;
  localparam int DST_W         = 9;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CH_BLUE  = 2'd0,
    CH_GREEN = 2'd1,
    CH_RED   = 2'd2
  } ch_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_ACC,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_OUT,
    ST_END,
    ST_EDGE_GO,
    ST_EDGE_WAIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic acc;
    logic mean_start;
    logic mean_load;
    ch_t  ch;
    logic out_load;
    logic end_step;
    logic edge_start;
    logic edge_load;
    logic edge_row;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic div_busy;
    logic div_done;
    logic out_free;
    logic need_row;
    logic need_col;
  } sts_t;

  function automatic logic [SRC_W-1:0] eff_src(input logic [SRC_W-1:0] v);
    logic [SRC_W-1:0] w;
    w = v;
    if (w == '0) w = SRC_W'(1);
    if (w > SRC_W'(MAX_SRC_DIM)) w = SRC_W'(MAX_SRC_DIM);
    return w;
  endfunction

  function automatic logic [DST_W-1:0] eff_dst(input logic [DST_W-1:0] v,
                                               input logic [SRC_W-1:0] lim,
                                               input logic [SRC_W-1:0] s);
    logic [SRC_W-1:0] w;
    w = SRC_W'(v);
    if (w == '0) w = SRC_W'(1);
    if (w > lim) w = lim;
    if (w > s) w = s;
    return w[DST_W-1:0];
  endfunction

endpackage

FILE: rtl/bads_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bads_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bads_div import bads_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0] q_r;
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W-1:0] den_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [CNT_W:0]   shifted;
  logic [CNT_W:0]   diff;
  logic             ge;

  assign shifted = {rem_r, q_r[DIV_W-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= dividend;
        rem_r  <= '0;
        den_r  <= divisor;
        cnt_r  <= 6'(DIV_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        q_r   <= {q_r[DIV_W-2:0], ge};
        rem_r <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: rtl/bads_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bads_dp
// datapath: config, position counters, column sum memory, divider, output
// ----------------------------------------------------------------------------
module bads_dp import bads_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_index,
  input  logic [SRC_W-1:0] cfg_data,
  output logic             cfg_ready,
  input  logic [7:0]       in_pix_blue,
  input  logic [7:0]       in_pix_green,
  input  logic [7:0]       in_pix_red,
  input  logic             in_frame_start,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_avg_blue,
  output logic [7:0]       out_avg_green,
  output logic [7:0]       out_avg_red,
  output logic [7:0]       out_out_row,
  output logic [7:0]       out_out_col,
  output logic             out_frame_end,
  input  cmd_t             cmd,
  output sts_t             sts
);

  logic [SRC_W-1:0] src_w_r, src_h_r;
  logic [DST_W-1:0] dst_w_r, dst_h_r;
  logic [SRC_W-1:0] sw, sh;
  logic [DST_W-1:0] dw, dh;

  logic [7:0]       pix_r [3];
  logic [POS_W-1:0] row_r, col_r, btop_r, bbot_r, bleft_r, bright_r;
  logic [IDX_W-1:0] band_r, blk_r;
  logic             blk_adv_r;

  logic [3*SUM_W-1:0] mem [MAX_DST_WIDTH];
  logic [MAX_DST_WIDTH-1:0] sv_r;
  logic [3*SUM_W-1:0] rd_r;
  logic               rdv_r;
  logic [SUM_W-1:0]   acc_r [3];
  logic [SUM_W-1:0]   acc_nxt [3];
  logic [CNT_W-1:0]   cnt_r;
  logic [7:0]         avg_r [3];
  logic [7:0]         orow_r, ocol_r;
  logic               fend_r;
  logic               ov_r;
  logic [7:0]         ob_r, og_r, orr_r, oro_r, oco_r;
  logic               ofe_r;

  logic [ADDR_W-1:0]  addr;
  logic               active, col_hit, row_hit, emit;
  logic               row_end, wrap, band_adv, clear;
  logic [SRC_W-1:0]   h, w;

  logic               div_busy, div_done, div_start;
  logic [DIV_W-1:0]   div_q, div_a;
  logic [CNT_W-1:0]   div_b;
  logic [IDX_W-1:0]   e_idx;
  logic [SRC_W-1:0]   e_s;
  logic [DST_W-1:0]   e_d;
  logic [21:0]        e_prod;
  logic [23:0]        e_num;
  logic [POS_W-1:0]   edge_val;
  logic [SUM_W-1:0]   mean_a;
  logic [7:0]         mean_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 12'd640;
      src_h_r <= 12'd480;
      dst_w_r <= 9'd80;
      dst_h_r <= 9'd60;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH:  src_w_r <= cfg_data;
        REG_SRC_HEIGHT: src_h_r <= cfg_data;
        REG_DST_WIDTH:  dst_w_r <= cfg_data[DST_W-1:0];
        REG_DST_HEIGHT: dst_h_r <= cfg_data[DST_W-1:0];
        default: ;
      endcase
    end
  end

  assign sw = eff_src(src_w_r);
  assign sh = eff_src(src_h_r);
  assign dw = eff_dst(dst_w_r, SRC_W'(MAX_DST_WIDTH), sw);
  assign dh = eff_dst(dst_h_r, SRC_W'(DST_H_LIMIT), sh);

  // block status from the current position
  assign addr     = blk_r[ADDR_W-1:0];
  assign active   = (band_r < dh) && (blk_r < dw);
  assign col_hit  = col_r >= bright_r;
  assign row_hit  = row_r >= bbot_r;
  assign emit     = active && col_hit && row_hit;
  assign row_end  = ({1'b0, col_r} + 12'd1) >= sw;
  assign wrap     = row_end && (({1'b0, row_r} + 12'd1) >= sh);
  assign band_adv = (band_r < dh) && row_hit;
  assign clear    = (cmd.accept && in_frame_start) || (cmd.end_step && wrap);

  assign h = (bbot_r >= btop_r) ? {1'b0, bbot_r - btop_r} + 12'd1 : 12'd1;
  assign w = (bright_r >= bleft_r) ? {1'b0, bright_r - bleft_r} + 12'd1 : 12'd1;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r[0] <= in_pix_blue;
      pix_r[1] <= in_pix_green;
      pix_r[2] <= in_pix_red;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_r     <= '0;
      band_r    <= '0;
      blk_r     <= '0;
      btop_r    <= '0;
      bleft_r   <= '0;
      bbot_r    <= '0;
      bright_r  <= '0;
      blk_adv_r <= 1'b0;
    end else begin
      if (clear) begin
        row_r   <= '0;
        col_r   <= '0;
        band_r  <= '0;
        blk_r   <= '0;
        btop_r  <= '0;
        bleft_r <= '0;
      end else if (cmd.end_step) begin
        if (row_end) begin
          col_r   <= '0;
          row_r   <= row_r + 11'd1;
          blk_r   <= '0;
          bleft_r <= '0;
          if (band_adv) begin
            band_r <= band_r + 9'd1;
            btop_r <= bbot_r + 11'd1;
          end
        end else begin
          col_r <= col_r + 11'd1;
        end
      end
      if (cmd.acc) begin
        blk_adv_r <= active && col_hit;
        if (active && col_hit) begin
          blk_r   <= blk_r + 9'd1;
          bleft_r <= bright_r + 11'd1;
        end
      end
      if (cmd.edge_load) begin
        if (cmd.edge_row) bbot_r <= edge_val;
        else bright_r <= edge_val;
      end
    end
  end

  // column sum memory, read registered
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_r  <= mem[addr];
      rdv_r <= sv_r[addr];
    end
    if (cmd.acc && active) mem[addr] <= {acc_nxt[2], acc_nxt[1], acc_nxt[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else if (clear) begin
      sv_r <= '0;
    end else if (cmd.acc && active) begin
      sv_r[addr] <= !emit;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_nxt[i] = (rdv_r ? rd_r[i*SUM_W +: SUM_W] : '0) + SUM_W'(pix_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      for (int i = 0; i < 3; i++) acc_r[i] <= acc_nxt[i];
      cnt_r  <= h * w;
      orow_r <= band_r[7:0];
      ocol_r <= blk_r[7:0];
      fend_r <= (band_r == dh - 9'd1) && (blk_r == dw - 9'd1);
    end
  end

  // shared divider: block edges and channel means
  assign e_idx  = cmd.edge_row ? band_r : blk_r;
  assign e_s    = cmd.edge_row ? sh : sw;
  assign e_d    = cmd.edge_row ? dh : dw;
  assign e_prod = ({1'b0, e_idx} + 10'd1) * e_s;
  assign e_num  = {1'b0, e_prod, 1'b0} + 24'(e_d);

  always_comb begin
    case (cmd.ch)
      CH_BLUE:  mean_a = acc_r[0];
      CH_GREEN: mean_a = acc_r[1];
      CH_RED:   mean_a = acc_r[2];
      default:  mean_a = acc_r[0];
    endcase
  end

  assign div_start = cmd.edge_start || cmd.mean_start;
  assign div_a     = cmd.edge_start ? DIV_W'(e_num) : mean_a;
  assign div_b     = cmd.edge_start ? CNT_W'({e_d, 1'b0}) : cnt_r;

  bads_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign edge_val = (div_q == '0) ? '0 : POS_W'(div_q - DIV_W'(1));
  assign mean_sat = (div_q > DIV_W'(255)) ? 8'd255 : div_q[7:0];

  always_ff @(posedge clk) begin
    if (cmd.mean_load) begin
      case (cmd.ch)
        CH_BLUE:  avg_r[0] <= mean_sat;
        CH_GREEN: avg_r[1] <= mean_sat;
        CH_RED:   avg_r[2] <= mean_sat;
        default:  avg_r[0] <= mean_sat;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ob_r  <= avg_r[0];
      og_r  <= avg_r[1];
      orr_r <= avg_r[2];
      oro_r <= orow_r;
      oco_r <= ocol_r;
      ofe_r <= fend_r;
    end
  end

  assign out_valid     = ov_r;
  assign out_avg_blue  = ob_r;
  assign out_avg_green = og_r;
  assign out_avg_red   = orr_r;
  assign out_out_row   = oro_r;
  assign out_out_col   = oco_r;
  assign out_frame_end = ofe_r;

  assign sts.emit     = emit;
  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign sts.out_free = !ov_r || !out_stall;
  assign sts.need_row = wrap || (row_end && band_adv && ((band_r + 9'd1) < dh));
  assign sts.need_col = row_end || (blk_adv_r && (blk_r < dw));

endmodule

FILE: rtl/bads_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bads_ctrl
// sequencer of one source pixel: accumulate, divide, output, edge updates
// ----------------------------------------------------------------------------
module bads_ctrl import bads_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_frame_start,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  ch_t    ch_r, ch_nxt;
  logic   need_row_r, need_row_nxt;
  logic   need_col_r, need_col_nxt;
  logic   front_r, front_nxt;
  logic   kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_EDGE_GO;
      ch_r       <= CH_BLUE;
      need_row_r <= 1'b1;
      need_col_r <= 1'b1;
      front_r    <= 1'b0;
      kind_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ch_r       <= ch_nxt;
      need_row_r <= need_row_nxt;
      need_col_r <= need_col_nxt;
      front_r    <= front_nxt;
      kind_r     <= kind_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    ch_nxt       = ch_r;
    need_row_nxt = need_row_r;
    need_col_nxt = need_col_r;
    front_nxt    = front_r;
    kind_nxt     = kind_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_frame_start) begin
            need_row_nxt = 1'b1;
            need_col_nxt = 1'b1;
            front_nxt    = 1'b1;
            state_nxt    = ST_EDGE_GO;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: state_nxt = ST_ACC;
      ST_ACC: begin
        ch_nxt    = CH_BLUE;
        state_nxt = sts.emit ? ST_MEAN_GO : ST_END;
      end
      ST_MEAN_GO: state_nxt = ST_MEAN_WAIT;
      ST_MEAN_WAIT: begin
        if (sts.div_done) begin
          case (ch_r)
            CH_BLUE: begin
              ch_nxt    = CH_GREEN;
              state_nxt = ST_MEAN_GO;
            end
            CH_GREEN: begin
              ch_nxt    = CH_RED;
              state_nxt = ST_MEAN_GO;
            end
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_OUT: if (sts.out_free) state_nxt = ST_END;
      ST_END: begin
        need_row_nxt = sts.need_row;
        need_col_nxt = sts.need_col;
        front_nxt    = 1'b0;
        state_nxt    = ST_EDGE_GO;
      end
      ST_EDGE_GO: begin
        if (need_row_r) begin
          kind_nxt  = 1'b1;
          state_nxt = ST_EDGE_WAIT;
        end else if (need_col_r) begin
          kind_nxt  = 1'b0;
          state_nxt = ST_EDGE_WAIT;
        end else begin
          state_nxt = front_r ? ST_RD : ST_IDLE;
        end
      end
      ST_EDGE_WAIT: begin
        if (sts.div_done) begin
          if (kind_r) need_row_nxt = 1'b0;
          else need_col_nxt = 1'b0;
          state_nxt = ST_EDGE_GO;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.ch   = ch_r;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_RD:        cmd.rd = 1'b1;
      ST_ACC:       cmd.acc = 1'b1;
      ST_MEAN_GO:   cmd.mean_start = 1'b1;
      ST_MEAN_WAIT: cmd.mean_load = sts.div_done;
      ST_OUT:       cmd.out_load = sts.out_free;
      ST_END:       cmd.end_step = 1'b1;
      ST_EDGE_GO: begin
        cmd.edge_start = need_row_r || need_col_r;
        cmd.edge_row   = need_row_r;
      end
      ST_EDGE_WAIT: begin
        cmd.edge_load = sts.div_done;
        cmd.edge_row  = kind_r;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/block_average_downscaler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_average_downscaler_top
// area-average image downscaler for a raster stream of rgb pixels
// ----------------------------------------------------------------------------
// source pixels enter on in_* (valid/stall), one request per pixel in raster
// order; in_frame_start on a pixel restarts the frame at that pixel.
// block means leave on out_* (valid/stall) through an output register, one
// request per finished block, with its output row, column and a frame end
// flag on the last block of the frame.
// cfg_* writes the source and output sizes (index = register number); it is
// always ready and should only be written while the block is idle.
// each pixel is handled alone by a sequencer: read, accumulate and step for
// a plain pixel, plus a new right edge through the shared 32-step divider
// when a block column closes, plus the three channel means and an output
// load when a block completes, plus new column and, where needed, band
// edges at the end of a source line or frame.
// a frame start pixel adds band and column edge divisions, then accumulates.
// after reset the first band and column edges are computed with in_stall
// high; column sums come up cleared via per-column valid bits.
// a stalled result holds the output register; the block keeps going until
// it has another result to hand over, then waits.
// ----------------------------------------------------------------------------
module block_average_downscaler_top import bads_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output logic        cfg_ready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pix_blue,
  input  logic [7:0]  in_pix_green,
  input  logic [7:0]  in_pix_red,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_avg_blue,
  output logic [7:0]  out_avg_green,
  output logic [7:0]  out_avg_red,
  output logic [7:0]  out_out_row,
  output logic [7:0]  out_out_col,
  output logic        out_frame_end
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  bads_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_frame_start (in_frame_start),
    .in_stall       (in_stall),
    .sts            (sts),
    .cmd            (cmd)
  );

  // counters, column sums, divider and output register
  bads_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cfg_ready      (cfg_ready),
    .in_pix_blue    (in_pix_blue),
    .in_pix_green   (in_pix_green),
    .in_pix_red     (in_pix_red),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_avg_blue   (out_avg_blue),
    .out_avg_green  (out_avg_green),
    .out_avg_red    (out_avg_red),
    .out_out_row    (out_out_row),
    .out_out_col    (out_out_col),
    .out_frame_end  (out_frame_end),
    .cmd            (cmd),
    .sts            (sts)
  );

  // divider only started when free
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.edge_start || cmd.mean_start) |-> !sts.div_busy)
    else $error("divider started while busy");

  // result never loaded over one still waiting
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  // a pixel is only taken with the divider idle
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !sts.div_busy)
    else $error("pixel accepted during division");

endmodule
